### rtl/im2row_gather_address_generator_core_macros.svh
// Assertion macros shared by the im2row gather address generator.
`ifndef IM2ROW_GATHER_ADDRESS_GENERATOR_CORE_MACROS_SVH
`define IM2ROW_GATHER_ADDRESS_GENERATOR_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define I2R_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define I2R_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/i2r_pkg.sv
// Shared constants and types of the im2row gather address generator.
package i2r_pkg;

   localparam int MAX_SIDE_DEF     = 4096;
   localparam int MAX_CHANNELS_DEF = 4096;
   localparam int ADDR_BITS_DEF    = 48;

   localparam int OFF_W   = 48;
   localparam int IDX_W   = 28;
   localparam int ROW_W   = 12;
   localparam int BATCH_W = 16;
   localparam int KDIM_W  = 8;
   localparam int HALF_W  = 24;

   localparam logic [2:0] REG_LAYOUT     = 3'd0;
   localparam logic [2:0] REG_ELEM_SIZE  = 3'd1;
   localparam logic [2:0] REG_EXTENT     = 3'd2;
   localparam logic [2:0] REG_KERNEL     = 3'd3;
   localparam logic [2:0] REG_ROW_STRIDE = 3'd4;
   localparam logic [2:0] REG_CH_STRIDE  = 3'd5;
   localparam logic [2:0] REG_PIX_STRIDE = 3'd6;
   localparam logic [2:0] REG_BAT_STRIDE = 3'd7;

   localparam logic [1:0] LAYOUT_CHANNELS_LAST = 2'd0;

   typedef struct packed {
      logic [BATCH_W-1:0] batch_index;
      logic [ROW_W-1:0]   out_row;
      logic [ROW_W-1:0]   out_col;
      logic [IDX_W-1:0]   elem_index;
   } i2r_req_type;

   typedef struct packed {
      logic [1:0]       layout_mode;
      logic             elem_size_code;
      logic [63:0]      kernel_geometry;
      logic [OFF_W-1:0] row_stride_bytes;
      logic [OFF_W-1:0] channel_stride_bytes;
      logic [OFF_W-1:0] pixel_stride_bytes;
      logic [OFF_W-1:0] batch_stride_bytes;
   } i2r_cfg_type;

endpackage

### rtl/i2r_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a payload.
module i2r_div #(
   parameter int NW = 28,
   parameter int DW = 16,
   parameter int PW = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_vld,
   input  logic [NW-1:0] dividend,
   input  logic [DW-1:0] divisor,
   input  logic [PW-1:0] in_pay,
   output logic          out_vld,
   output logic [NW-1:0] quo,
   output logic [DW-1:0] rem,
   output logic [PW-1:0] out_pay
);

   logic [NW-1:0] vld_ff;
   logic [NW-1:0] vld_in;
   logic [DW-1:0] rem_ff  [NW];
   logic [DW-1:0] rem_in  [NW];
   logic [NW-1:0] num_ff  [NW];
   logic [NW-1:0] num_in  [NW];
   logic [PW-1:0] pay_ff  [NW];
   logic [PW-1:0] pay_in  [NW];

   assign vld_in = {vld_ff[NW-2:0], in_vld};

   for (genvar g = 0; g < NW; g++) begin : g_stage
      logic [DW-1:0] rem_prev;
      logic [NW-1:0] num_prev;
      logic [DW:0]   trial;
      logic [DW:0]   diff;
      logic          take;

      if (g == 0) begin : g_first
         assign rem_prev  = '0;
         assign num_prev  = dividend;
         assign pay_in[g] = in_pay;
      end else begin : g_rest
         assign rem_prev  = rem_ff[g-1];
         assign num_prev  = num_ff[g-1];
         assign pay_in[g] = pay_ff[g-1];
      end

      // Bring down the next dividend bit and subtract where it fits.
      assign trial     = {rem_prev, num_prev[NW-1]};
      assign diff      = trial - {1'b0, divisor};
      assign take      = trial >= {1'b0, divisor};
      assign rem_in[g] = take ? diff[DW-1:0] : trial[DW-1:0];
      assign num_in[g] = {num_prev[NW-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
      if (en) begin
         for (int i = 0; i < NW; i++) begin
            rem_ff[i] <= rem_in[i];
            num_ff[i] <= num_in[i];
            pay_ff[i] <= pay_in[i];
         end
      end
   end

   assign out_vld = vld_ff[NW-1];
   assign quo     = num_ff[NW-1];
   assign rem     = rem_ff[NW-1];
   assign out_pay = pay_ff[NW-1];

endmodule

### rtl/i2r_addr.sv
// Coordinate, bounds and byte offset stages that follow the index split.
module i2r_addr
   import i2r_pkg::*;
#(
   parameter int MAX_SIDE     = MAX_SIDE_DEF,
   parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
   parameter int ADDR_BITS    = ADDR_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   en,
   input  i2r_cfg_type                            cfg,
   input  logic [$clog2(MAX_SIDE+1)-1:0]          ih_n,
   input  logic [$clog2(MAX_SIDE+1)-1:0]          iw_n,
   input  logic [2*KDIM_W+$clog2(MAX_CHANNELS+1)-1:0] total,
   input  logic                                   in_vld,
   input  i2r_req_type                            req,
   input  logic [((($clog2(MAX_CHANNELS+1)) > KDIM_W) ?
                  $clog2(MAX_CHANNELS+1) : KDIM_W)-1:0] r1,
   input  logic [IDX_W-1:0]                       q2,
   input  logic [KDIM_W-1:0]                      r2,
   output logic                                   out_vld,
   output logic [OFF_W-1:0]                       byte_offset,
   output logic                                   zero_fill,
   output logic                                   index_error
);

   localparam int SIDE_W = $clog2(MAX_SIDE + 1);
   localparam int CH_W   = $clog2(MAX_CHANNELS + 1);
   localparam int PIX_W  = 2 * SIDE_W;
   localparam int OPA_W  = (PIX_W > CH_W) ? PIX_W : CH_W;
   localparam int CRD_W  = 22;
   localparam int AW     = (ADDR_BITS < OFF_W) ? ADDR_BITS : OFF_W;
   localparam logic [OFF_W-1:0] ADDR_MASK = {OFF_W{1'b1}} >> (OFF_W - AW);

   logic mode_cl;
   logic chan_major;
   assign mode_cl    = cfg.layout_mode == LAYOUT_CHANNELS_LAST;
   assign chan_major = cfg.layout_mode[1];

   // Stage 1: kernel tap, channel and input coordinates.
   logic [KDIM_W-1:0]  kh;
   logic [KDIM_W-1:0]  kw;
   logic [CH_W-1:0]    c_sel;
   logic [19:0]        prow;
   logic [19:0]        pcol;
   logic [16:0]        ptap_h;
   logic [16:0]        ptap_w;
   logic [8:0]         dil_h;
   logic [8:0]         dil_w;

   logic               vld1_ff;
   logic [CRD_W-1:0]   ih1_ff, ih1_in;
   logic [CRD_W-1:0]   iw1_ff, iw1_in;
   logic [CH_W-1:0]    c1_ff;
   logic [BATCH_W-1:0] b1_ff;
   logic               err1_ff, err1_in;

   always_comb begin
      if (chan_major) begin
         kw    = r1[KDIM_W-1:0];
         kh    = r2;
         c_sel = q2[CH_W-1:0];
      end else begin
         kw    = r2;
         kh    = q2[KDIM_W-1:0];
         c_sel = r1[CH_W-1:0];
      end
   end

   assign dil_h  = {1'b0, cfg.kernel_geometry[39:32]} + 9'd1;
   assign dil_w  = {1'b0, cfg.kernel_geometry[47:40]} + 9'd1;
   assign prow   = req.out_row * cfg.kernel_geometry[23:16];
   assign pcol   = req.out_col * cfg.kernel_geometry[31:24];
   assign ptap_h = kh * dil_h;
   assign ptap_w = kw * dil_w;
   assign ih1_in = {2'b0, prow} + {5'b0, ptap_h} - {14'b0, cfg.kernel_geometry[55:48]};
   assign iw1_in = {2'b0, pcol} + {5'b0, ptap_w} - {14'b0, cfg.kernel_geometry[63:56]};
   assign err1_in = 64'(req.elem_index) >= 64'(total);

   // Stage 2: bounds check and the pixel number for channels-last.
   logic               vld2_ff;
   logic               zf2_ff, zf2_in;
   logic               err2_ff;
   logic [PIX_W-1:0]   pix2_ff, pix2_in;
   logic [SIDE_W-1:0]  ih2_ff;
   logic [SIDE_W-1:0]  iw2_ff;
   logic [CH_W-1:0]    c2_ff;
   logic [BATCH_W-1:0] b2_ff;

   assign zf2_in  = ih1_ff[CRD_W-1] || (ih1_ff[CRD_W-2:0] >= (CRD_W-1)'(ih_n)) ||
                    iw1_ff[CRD_W-1] || (iw1_ff[CRD_W-2:0] >= (CRD_W-1)'(iw_n));
   assign pix2_in = ih1_ff[SIDE_W-1:0] * iw_n + PIX_W'(iw1_ff[SIDE_W-1:0]);

   // Stage 3: half-width partial products of the three stride terms.
   logic [OPA_W-1:0]          a1;
   logic [OFF_W-1:0]          s1;
   logic [SIDE_W-1:0]         a2;
   logic [OPA_W-1:0]          e_base;

   logic                      vld3_ff;
   logic                      zf3_ff;
   logic                      err3_ff;
   logic [OPA_W+HALF_W-1:0]   p1lo_ff, p1lo_in, p1hi_ff, p1hi_in;
   logic [SIDE_W+HALF_W-1:0]  p2lo_ff, p2lo_in, p2hi_ff, p2hi_in;
   logic [BATCH_W+HALF_W-1:0] p3lo_ff, p3lo_in, p3hi_ff, p3hi_in;
   logic [OFF_W-1:0]          e3_ff, e3_in;

   assign a1     = mode_cl ? OPA_W'(pix2_ff) : OPA_W'(c2_ff);
   assign s1     = mode_cl ? cfg.pixel_stride_bytes : cfg.channel_stride_bytes;
   assign a2     = mode_cl ? '0 : ih2_ff;
   assign e_base = mode_cl ? OPA_W'(c2_ff) : OPA_W'(iw2_ff);
   assign e3_in  = cfg.elem_size_code ? (OFF_W'(e_base) << 2) : (OFF_W'(e_base) << 1);

   assign p1lo_in = a1 * s1[HALF_W-1:0];
   assign p1hi_in = a1 * s1[OFF_W-1:HALF_W];
   assign p2lo_in = a2 * cfg.row_stride_bytes[HALF_W-1:0];
   assign p2hi_in = a2 * cfg.row_stride_bytes[OFF_W-1:HALF_W];
   assign p3lo_in = b2_ff * cfg.batch_stride_bytes[HALF_W-1:0];
   assign p3hi_in = b2_ff * cfg.batch_stride_bytes[OFF_W-1:HALF_W];

   // Stage 4: recombine each product modulo the offset width.
   logic             vld4_ff;
   logic             zf4_ff;
   logic             err4_ff;
   logic [OFF_W-1:0] t1_ff, t1_in, t2_ff, t2_in, t3_ff, t3_in, e4_ff;

   assign t1_in = OFF_W'(p1lo_ff) + {p1hi_ff[HALF_W-1:0], {HALF_W{1'b0}}};
   assign t2_in = OFF_W'(p2lo_ff) + {p2hi_ff[HALF_W-1:0], {HALF_W{1'b0}}};
   assign t3_in = OFF_W'(p3lo_ff) + {p3hi_ff[HALF_W-1:0], {HALF_W{1'b0}}};

   // Stage 5: pairwise sums.
   logic             vld5_ff;
   logic             zf5_ff;
   logic             err5_ff;
   logic [OFF_W-1:0] u1_ff, u1_in, u2_ff, u2_in;

   assign u1_in = t1_ff + t2_ff;
   assign u2_in = t3_ff + e4_ff;

   // Stage 6: result register.
   logic             vld6_ff;
   logic [OFF_W-1:0] off6_ff, off6_in;
   logic             zf6_ff, zf6_in;
   logic             err6_ff;
   logic [OFF_W-1:0] sum5;

   assign sum5    = (u1_ff + u2_ff) & ADDR_MASK;
   assign off6_in = (zf5_ff || err5_ff) ? '0 : sum5;
   assign zf6_in  = zf5_ff && !err5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
         vld4_ff <= 1'b0;
         vld5_ff <= 1'b0;
         vld6_ff <= 1'b0;
      end else if (en) begin
         vld1_ff <= in_vld;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
         vld4_ff <= vld3_ff;
         vld5_ff <= vld4_ff;
         vld6_ff <= vld5_ff;
      end
      if (en) begin
         ih1_ff  <= ih1_in;
         iw1_ff  <= iw1_in;
         c1_ff   <= c_sel;
         b1_ff   <= req.batch_index;
         err1_ff <= err1_in;

         zf2_ff  <= zf2_in;
         err2_ff <= err1_ff;
         pix2_ff <= pix2_in;
         ih2_ff  <= ih1_ff[SIDE_W-1:0];
         iw2_ff  <= iw1_ff[SIDE_W-1:0];
         c2_ff   <= c1_ff;
         b2_ff   <= b1_ff;

         zf3_ff  <= zf2_ff;
         err3_ff <= err2_ff;
         p1lo_ff <= p1lo_in;
         p1hi_ff <= p1hi_in;
         p2lo_ff <= p2lo_in;
         p2hi_ff <= p2hi_in;
         p3lo_ff <= p3lo_in;
         p3hi_ff <= p3hi_in;
         e3_ff   <= e3_in;

         zf4_ff  <= zf3_ff;
         err4_ff <= err3_ff;
         t1_ff   <= t1_in;
         t2_ff   <= t2_in;
         t3_ff   <= t3_in;
         e4_ff   <= e3_ff;

         zf5_ff  <= zf4_ff;
         err5_ff <= err4_ff;
         u1_ff   <= u1_in;
         u2_ff   <= u2_in;

         off6_ff <= off6_in;
         zf6_ff  <= zf6_in;
         err6_ff <= err5_ff;
      end
   end

   assign out_vld     = vld6_ff;
   assign byte_offset = off6_ff;
   assign zero_fill   = zf6_ff;
   assign index_error = err6_ff;

endmodule

### rtl/im2row_gather_address_generator_core.sv
// Top level of the im2row gather address generator.
// Pipeline: 28 stages in each of two bit-per-stage dividers followed by six coordinate
// and offset stages.
// Throughput: one request per cycle; the whole pipeline holds when the result
// register is full and not taken.
// Reset: synchronous; valid and configuration registers return to their defaults and the pipeline empties.
`include "im2row_gather_address_generator_core_macros.svh"

module im2row_gather_address_generator_core
   import i2r_pkg::*;
#(
   parameter int MAX_SIDE     = MAX_SIDE_DEF,
   parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
   parameter int ADDR_BITS    = ADDR_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [2:0]         csr_index,
   input  logic [63:0]        csr_write_data,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [BATCH_W-1:0] req_batch_index,
   input  logic [ROW_W-1:0]   req_out_row,
   input  logic [ROW_W-1:0]   req_out_col,
   input  logic [IDX_W-1:0]   req_elem_index,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [OFF_W-1:0]   rsp_byte_offset,
   output logic               rsp_zero_fill,
   output logic               rsp_index_error
);

   localparam int SIDE_W = $clog2(MAX_SIDE + 1);
   localparam int CH_W   = $clog2(MAX_CHANNELS + 1);
   localparam int DW1    = (CH_W > KDIM_W) ? CH_W : KDIM_W;
   localparam int REQ_W  = $bits(i2r_req_type);

   // Configuration registers.
   i2r_cfg_type      cfg_ff;
   logic [OFF_W-1:0] extent_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.layout_mode          <= LAYOUT_CHANNELS_LAST;
         cfg_ff.elem_size_code       <= 1'b1;
         cfg_ff.kernel_geometry      <= '0;
         cfg_ff.row_stride_bytes     <= '0;
         cfg_ff.channel_stride_bytes <= '0;
         cfg_ff.pixel_stride_bytes   <= '0;
         cfg_ff.batch_stride_bytes   <= '0;
         extent_ff                   <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_LAYOUT:     cfg_ff.layout_mode          <= csr_write_data[1:0];
            REG_ELEM_SIZE:  cfg_ff.elem_size_code       <= csr_write_data[0];
            REG_EXTENT:     extent_ff                   <= csr_write_data[OFF_W-1:0];
            REG_KERNEL:     cfg_ff.kernel_geometry      <= csr_write_data;
            REG_ROW_STRIDE: cfg_ff.row_stride_bytes     <= csr_write_data[OFF_W-1:0];
            REG_CH_STRIDE:  cfg_ff.channel_stride_bytes <= csr_write_data[OFF_W-1:0];
            REG_PIX_STRIDE: cfg_ff.pixel_stride_bytes   <= csr_write_data[OFF_W-1:0];
            REG_BAT_STRIDE: cfg_ff.batch_stride_bytes   <= csr_write_data[OFF_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Extents saturate at the configured limits.
   logic [SIDE_W-1:0] ih_n;
   logic [SIDE_W-1:0] iw_n;
   logic [CH_W-1:0]   ic_n;
   logic [KDIM_W-1:0] kh_n;
   logic [KDIM_W-1:0] kw_n;

   assign ih_n = (32'(extent_ff[15:0]) > MAX_SIDE) ? SIDE_W'(MAX_SIDE) : SIDE_W'(extent_ff[15:0]);
   assign iw_n = (32'(extent_ff[31:16]) > MAX_SIDE) ? SIDE_W'(MAX_SIDE)
                                                     : SIDE_W'(extent_ff[31:16]);
   assign ic_n = (32'(extent_ff[47:32]) > MAX_CHANNELS) ? CH_W'(MAX_CHANNELS)
                                                         : CH_W'(extent_ff[47:32]);
   assign kh_n = cfg_ff.kernel_geometry[7:0];
   assign kw_n = cfg_ff.kernel_geometry[15:8];

   // Row length, recomputed every cycle from the registers. It is only compared
   // far down the pipeline, against its value at that time rather than at request transfer.
   logic [2*KDIM_W-1:0]       kk_ff, kk_in;
   logic [2*KDIM_W+CH_W-1:0]  total_ff, total_in;

   assign kk_in    = kh_n * kw_n;
   assign total_in = kk_ff * ic_n;

   always_ff @(posedge clock) begin
      kk_ff    <= kk_in;
      total_ff <= total_in;
   end

   // A single hold signal freezes every stage while a result waits.
   logic en;
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   // First split: by the channel count in tap-major modes, otherwise by the
   // kernel width. The second split divides that quotient again.
   logic chan_major;
   assign chan_major = cfg_ff.layout_mode[1];

   i2r_req_type        req;
   logic [DW1-1:0]     d1;
   logic [KDIM_W-1:0]  d2;

   assign req.batch_index = req_batch_index;
   assign req.out_row     = req_out_row;
   assign req.out_col     = req_out_col;
   assign req.elem_index  = req_elem_index;
   assign d1 = chan_major ? DW1'(kw_n) : DW1'(ic_n);
   assign d2 = chan_major ? kh_n : kw_n;

   logic              v1;
   logic [IDX_W-1:0]  q1;
   logic [DW1-1:0]    r1;
   logic [REQ_W-1:0]  pay1;

   i2r_div #(.NW(IDX_W), .DW(DW1), .PW(REQ_W)) u_div_a (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (req_valid),
      .dividend (req_elem_index),
      .divisor  (d1),
      .in_pay   (req),
      .out_vld  (v1),
      .quo      (q1),
      .rem      (r1),
      .out_pay  (pay1)
   );

   logic                  v2;
   logic [IDX_W-1:0]      q2;
   logic [KDIM_W-1:0]     r2;
   logic [REQ_W+DW1-1:0]  pay2;
   i2r_req_type           req2;
   logic [DW1-1:0]        r1_d;

   i2r_div #(.NW(IDX_W), .DW(KDIM_W), .PW(REQ_W + DW1)) u_div_b (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (v1),
      .dividend (q1),
      .divisor  (d2),
      .in_pay   ({pay1, r1}),
      .out_vld  (v2),
      .quo      (q2),
      .rem      (r2),
      .out_pay  (pay2)
   );

   assign req2 = pay2[REQ_W+DW1-1:DW1];
   assign r1_d = pay2[DW1-1:0];

   i2r_addr #(
      .MAX_SIDE     (MAX_SIDE),
      .MAX_CHANNELS (MAX_CHANNELS),
      .ADDR_BITS    (ADDR_BITS)
   ) u_addr (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .cfg         (cfg_ff),
      .ih_n        (ih_n),
      .iw_n        (iw_n),
      .total       (total_ff),
      .in_vld      (v2),
      .req         (req2),
      .r1          (r1_d),
      .q2          (q2),
      .r2          (r2),
      .out_vld     (rsp_valid),
      .byte_offset (rsp_byte_offset),
      .zero_fill   (rsp_zero_fill),
      .index_error (rsp_index_error)
   );

   // A flagged element never carries an offset, and the two flags exclude.
   `I2R_ASSERT_NOW(a_err_clean, clock, reset, rsp_valid && rsp_index_error, !rsp_zero_fill && (rsp_byte_offset == '0), "index error result not clean")
   `I2R_ASSERT_NOW(a_fill_zero, clock, reset, rsp_valid && rsp_zero_fill, rsp_byte_offset == '0, "zero fill result has offset")
   // A held result blocks new transfers on the request side.
   `I2R_ASSERT_NOW(a_hold_blocks, clock, reset, rsp_valid && !rsp_ready, !req_ready, "request taken while result held")

endmodule
